FILE: src/arlt_pkg.sv
// ---------------------------------------------------------------------------
// arlt_pkg: shared definitions for the address region table
// Operation and status codes, default sizes and the cell control bundle.
// ---------------------------------------------------------------------------
package arlt_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int ADDR_BITS_DEF     = 48;

  localparam int OP_W      = 2;
  localparam int SEG_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int REMOVED_W = 8;

  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic cmp_en;   // latch match flags against the query
    logic add_op;   // query end address also counts as a match
    logic wr_en;    // write the selected cell
    logic clr;      // drop matched entries
    logic shift;    // one compaction step
  } cell_ctl_t;

endpackage

FILE: src/arlt_cell.sv
// ---------------------------------------------------------------------------
// arlt_cell: one table slot
// Holds one range, compares it with the query and takes part in compaction
// by pulling its successor's contents into an empty slot.
// ---------------------------------------------------------------------------
module arlt_cell #(
  parameter int ADDR_BITS = arlt_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  arlt_pkg::cell_ctl_t        ctl,
  input  logic                       wr_sel,
  input  logic [ADDR_BITS-1:0]       q_addr,
  input  logic [ADDR_BITS-1:0]       q_end,
  input  logic [arlt_pkg::SEG_W-1:0] q_seg,
  input  logic                       prv_valid,
  input  logic                       nxt_valid,
  input  logic [ADDR_BITS-1:0]       nxt_start,
  input  logic [ADDR_BITS-1:0]       nxt_end,
  input  logic [arlt_pkg::SEG_W-1:0] nxt_seg,
  input  logic                       nxt_match,
  output logic                       valid_o,
  output logic [ADDR_BITS-1:0]       start_o,
  output logic [ADDR_BITS-1:0]       end_o,
  output logic [arlt_pkg::SEG_W-1:0] seg_o,
  output logic                       match_o
);

  logic                       valid_r, valid_nxt;
  logic                       match_r, match_nxt;
  logic [ADDR_BITS-1:0]       start_r, start_nxt;
  logic [ADDR_BITS-1:0]       end_r, end_nxt;
  logic [arlt_pkg::SEG_W-1:0] seg_r, seg_nxt;
  logic                       hit_a, hit_e;

  assign hit_a = (q_addr >= start_r) && (q_addr < end_r);
  assign hit_e = (q_end >= start_r) && (q_end < end_r);

  always_comb begin
    valid_nxt = valid_r;
    match_nxt = match_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    seg_nxt   = seg_r;
    if (ctl.wr_en && wr_sel) begin
      valid_nxt = 1'b1;
      start_nxt = q_addr;
      end_nxt   = q_end;
      seg_nxt   = q_seg;
    end
    if (ctl.cmp_en) begin
      match_nxt = valid_r && (hit_a || (ctl.add_op && hit_e));
    end
    if (ctl.clr) begin
      valid_nxt = valid_r && !match_r;
    end
    if (ctl.shift) begin
      match_nxt = nxt_match;
      if (!valid_r) begin
        valid_nxt = nxt_valid;
        start_nxt = nxt_start;
        end_nxt   = nxt_end;
        seg_nxt   = nxt_seg;
      end else if (!prv_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
    start_r <= start_nxt;
    end_r   <= end_nxt;
    seg_r   <= seg_nxt;
  end

  assign valid_o = valid_r;
  assign start_o = start_r;
  assign end_o   = end_r;
  assign seg_o   = seg_r;
  assign match_o = match_r;

endmodule

FILE: src/arlt_tree.sv
// ---------------------------------------------------------------------------
// arlt_tree: registered first-match selection
// Binary tree over the cell match flags, one register level per stage;
// the lower slot wins at every node.
// ---------------------------------------------------------------------------
module arlt_tree #(
  parameter int ADDR_BITS = arlt_pkg::ADDR_BITS_DEF,
  parameter int LEAVES    = arlt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       leaf_hit   [LEAVES],
  input  logic [ADDR_BITS-1:0]       leaf_start [LEAVES],
  input  logic [ADDR_BITS-1:0]       leaf_end   [LEAVES],
  input  logic [arlt_pkg::SEG_W-1:0] leaf_seg   [LEAVES],
  output logic                       root_hit,
  output logic [ADDR_BITS-1:0]       root_start,
  output logic [ADDR_BITS-1:0]       root_end,
  output logic [arlt_pkg::SEG_W-1:0] root_seg
);

  localparam int LVLS = $clog2(LEAVES);
  localparam int NL   = 1 << LVLS;

  typedef struct packed {
    logic                       hit;
    logic [ADDR_BITS-1:0]       rng_start;
    logic [ADDR_BITS-1:0]       rng_end;
    logic [arlt_pkg::SEG_W-1:0] rng_seg;
  } node_t;

  node_t leaf_w [NL];
  node_t node_r [1:NL-1];

  for (genvar i = 0; i < NL; i++) begin : g_leaf
    if (i < LEAVES) begin : g_real
      assign leaf_w[i] = '{hit: leaf_hit[i], rng_start: leaf_start[i],
                           rng_end: leaf_end[i], rng_seg: leaf_seg[i]};
    end else begin : g_pad
      assign leaf_w[i] = '0;
    end
  end

  for (genvar j = 1; j < NL; j++) begin : g_node
    node_t lc, rc;
    if (2 * j >= NL) begin : g_from_leaf
      assign lc = leaf_w[2 * j - NL];
      assign rc = leaf_w[2 * j + 1 - NL];
    end else begin : g_from_node
      assign lc = node_r[2 * j];
      assign rc = node_r[2 * j + 1];
    end
    always_ff @(posedge clk) begin
      node_r[j] <= lc.hit ? lc : rc;
    end
  end

  assign root_hit   = node_r[1].hit;
  assign root_start = node_r[1].rng_start;
  assign root_end   = node_r[1].rng_end;
  assign root_seg   = node_r[1].rng_seg;

endmodule

FILE: src/address_region_table.sv
// ---------------------------------------------------------------------------
// address_region_table: packed table of mapped address ranges
// Find / add / remove over a row of slot cells with a first-match tree.
// Find and add pass through the compare, tree and result states before the
// output register; remove skips the tree and runs the neighbor-to-neighbor
// compaction steps after the result state. One transaction at a time;
// the next one is accepted while the previous result waits at the output.
// Reset: synchronous; the table is empty right after reset, no clear pass.
// ---------------------------------------------------------------------------
module address_region_table #(
  parameter int TABLE_ENTRIES = arlt_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = arlt_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [arlt_pkg::OP_W-1:0]      in_operation,
  input  logic [ADDR_BITS-1:0]           in_address,
  input  logic [ADDR_BITS-1:0]           in_length,
  input  logic [arlt_pkg::SEG_W-1:0]     in_segment_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [arlt_pkg::STATUS_W-1:0]  out_status,
  output logic [arlt_pkg::SEG_W-1:0]     out_hit_segment_id,
  output logic [ADDR_BITS-1:0]           out_hit_start,
  output logic [ADDR_BITS-1:0]           out_hit_end,
  output logic [arlt_pkg::REMOVED_W-1:0] out_removed_count
);

  localparam int N      = TABLE_ENTRIES;
  localparam int LVLS   = $clog2(N);
  localparam int CNT_W  = $clog2(N + 1);
  localparam int STEP_W = $clog2(2 * N);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CMP     = 6'b000010,
    S_TREE    = 6'b000100,
    S_RES     = 6'b001000,
    S_COMPACT = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [STEP_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]               used_r, used_nxt;
  logic [CNT_W-1:0]               rem_r, rem_nxt;
  logic [arlt_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [ADDR_BITS-1:0]           addr_r, addr_nxt;
  logic [ADDR_BITS-1:0]           end_r, end_nxt;
  logic [arlt_pkg::SEG_W-1:0]     sid_r, sid_nxt;
  logic [arlt_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [arlt_pkg::SEG_W-1:0]     res_seg_r, res_seg_nxt;
  logic [ADDR_BITS-1:0]           res_start_r, res_start_nxt;
  logic [ADDR_BITS-1:0]           res_end_r, res_end_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [arlt_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [arlt_pkg::SEG_W-1:0]     out_seg_r, out_seg_nxt;
  logic [ADDR_BITS-1:0]           out_start_r, out_start_nxt;
  logic [ADDR_BITS-1:0]           out_end_r, out_end_nxt;
  logic [CNT_W-1:0]               out_rem_r, out_rem_nxt;

  logic [ADDR_BITS:0]             sum;
  logic                           in_acc;
  arlt_pkg::cell_ctl_t            ctl;

  logic                           cell_valid [N];
  logic [ADDR_BITS-1:0]           cell_start [N];
  logic [ADDR_BITS-1:0]           cell_end   [N];
  logic [arlt_pkg::SEG_W-1:0]     cell_seg   [N];
  logic                           cell_match [N];

  logic                           root_hit;
  logic [ADDR_BITS-1:0]           root_start;
  logic [ADDR_BITS-1:0]           root_end;
  logic [arlt_pkg::SEG_W-1:0]     root_seg;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sum      = {1'b0, in_address} + {1'b0, in_length};

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                       prv_v;
    logic                       nv, nm;
    logic [ADDR_BITS-1:0]       ns, ne;
    logic [arlt_pkg::SEG_W-1:0] nsg;
    if (i == 0) begin : g_first
      assign prv_v = 1'b1;
    end else begin : g_mid
      assign prv_v = cell_valid[i-1];
    end
    if (i == N - 1) begin : g_last
      assign nv  = 1'b0;
      assign nm  = 1'b0;
      assign ns  = '0;
      assign ne  = '0;
      assign nsg = '0;
    end else begin : g_link
      assign nv  = cell_valid[i+1];
      assign nm  = cell_match[i+1];
      assign ns  = cell_start[i+1];
      assign ne  = cell_end[i+1];
      assign nsg = cell_seg[i+1];
    end
    arlt_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr_sel    (used_r == CNT_W'(i)),
      .q_addr    (addr_r),
      .q_end     (end_r),
      .q_seg     (sid_r),
      .prv_valid (prv_v),
      .nxt_valid (nv),
      .nxt_start (ns),
      .nxt_end   (ne),
      .nxt_seg   (nsg),
      .nxt_match (nm),
      .valid_o   (cell_valid[i]),
      .start_o   (cell_start[i]),
      .end_o     (cell_end[i]),
      .seg_o     (cell_seg[i]),
      .match_o   (cell_match[i])
    );
  end

  arlt_tree #(.ADDR_BITS(ADDR_BITS), .LEAVES(N)) u_tree (
    .clk        (clk),
    .leaf_hit   (cell_match),
    .leaf_start (cell_start),
    .leaf_end   (cell_end),
    .leaf_seg   (cell_seg),
    .root_hit   (root_hit),
    .root_start (root_start),
    .root_end   (root_end),
    .root_seg   (root_seg)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    rem_nxt        = rem_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    end_nxt        = end_r;
    sid_nxt        = sid_r;
    res_status_nxt = res_status_r;
    res_seg_nxt    = res_seg_r;
    res_start_nxt  = res_start_r;
    res_end_nxt    = res_end_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_seg_nxt    = out_seg_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_rem_nxt    = out_rem_r;
    ctl            = '0;
    ctl.add_op     = (op_r == arlt_pkg::OP_ADD);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_operation;
          addr_nxt  = in_address;
          end_nxt   = sum[ADDR_BITS] ? '1 : sum[ADDR_BITS-1:0];
          sid_nxt   = in_segment_id;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmp_en = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = (op_r == arlt_pkg::OP_REMOVE) ? S_RES : S_TREE;
      end
      S_TREE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(LVLS - 1)) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        res_status_nxt = arlt_pkg::ST_MISS;
        res_seg_nxt    = '0;
        res_start_nxt  = '0;
        res_end_nxt    = '0;
        rem_nxt        = '0;
        state_nxt      = S_DONE;
        case (op_r)
          arlt_pkg::OP_FIND: begin
            if (root_hit) begin
              res_status_nxt = arlt_pkg::ST_OK;
              res_seg_nxt    = root_seg;
              res_start_nxt  = root_start;
              res_end_nxt    = root_end;
            end
          end
          arlt_pkg::OP_ADD: begin
            if (addr_r == '0) begin
              res_status_nxt = arlt_pkg::ST_ZERO;
            end else if (root_hit) begin
              res_status_nxt = arlt_pkg::ST_OVERLAP;
            end else if (used_r == CNT_W'(N)) begin
              res_status_nxt = arlt_pkg::ST_FULL;
            end else begin
              res_status_nxt = arlt_pkg::ST_OK;
              ctl.wr_en      = 1'b1;
              used_nxt       = used_r + 1'b1;
            end
          end
          arlt_pkg::OP_REMOVE: begin
            res_status_nxt = arlt_pkg::ST_OK;
            ctl.clr        = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = S_COMPACT;
          end
          default: begin
          end
        endcase
      end
      S_COMPACT: begin
        ctl.shift = 1'b1;
        rem_nxt   = rem_r + CNT_W'(cell_match[0]);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(2 * N - 1)) begin
          used_nxt  = used_r - rem_nxt;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_seg_nxt    = res_seg_r;
          out_start_nxt  = res_start_r;
          out_end_nxt    = res_end_r;
          out_rem_nxt    = rem_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      used_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    end_r        <= end_nxt;
    sid_r        <= sid_nxt;
    res_status_r <= res_status_nxt;
    res_seg_r    <= res_seg_nxt;
    res_start_r  <= res_start_nxt;
    res_end_r    <= res_end_nxt;
    out_status_r <= out_status_nxt;
    out_seg_r    <= out_seg_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_rem_r    <= out_rem_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_hit_segment_id = out_seg_r;
  assign out_hit_start      = out_start_r;
  assign out_hit_end        = out_end_r;
  assign out_removed_count  = arlt_pkg::REMOVED_W'(out_rem_r);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for address_region_table
// Drives find, add, remove and unused-opcode transactions, predicts every result from a
// software copy of the region table and compares each returned field.
// ---------------------------------------------------------------------------
module tb_top;
  import arlt_pkg::*;

  localparam int N_SLOTS = TABLE_ENTRIES_DEF;
  localparam int AW      = ADDR_BITS_DEF;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // copy 0 steers stimulus generation, copy 1 predicts results at run time
  localparam int PLAN  = 0;
  localparam int CHECK = 1;

  typedef logic [AW-1:0] addr_t;
  localparam addr_t ADDR_MAX  = '1;
  localparam addr_t NEST_BASE = 48'h8000_0000_0000;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    addr_t            address;
    addr_t            length;
    logic [SEG_W-1:0] seg;
  } region_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SEG_W-1:0]     seg;
    addr_t                start;
    addr_t                stop;
    logic [REMOVED_W-1:0] removed;
  } region_resp_t;

  logic                   clk;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [OP_W-1:0]        in_operation  = OP_FIND;
  addr_t                  in_address    = '0;
  addr_t                  in_length     = '0;
  logic [SEG_W-1:0]       in_segment_id = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [SEG_W-1:0]       out_hit_segment_id;
  addr_t                  out_hit_start;
  addr_t                  out_hit_end;
  logic [REMOVED_W-1:0]   out_removed_count;

  addr_t            slot_start [2][N_SLOTS];
  addr_t            slot_end   [2][N_SLOTS];
  logic [SEG_W-1:0] slot_seg   [2][N_SLOTS];
  int               slots_used [2] = '{0, 0};

  region_req_t  request_queue[$];
  region_resp_t region_results_due[$];
  region_req_t  next_req;
  region_req_t  seen_req;
  region_resp_t want_resp;

  int       mismatches    = 0;
  int       reqs_accepted = 0;
  int       total_reqs    = 0;
  int       send_gap      = 0;
  int       recv_burst    = 0;
  int       hold_left     = 0;
  logic     hold_done     = 1'b0;
  logic     long_hold;
  logic [7:0] cycle_cnt   = '0;
  int       send_idle_pct = 15;
  int       recv_idle_pct = 15;

  address_region_table DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_address         (in_address),
    .in_length          (in_length),
    .in_segment_id      (in_segment_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_hit_segment_id (out_hit_segment_id),
    .out_hit_start      (out_hit_start),
    .out_hit_end        (out_hit_end),
    .out_removed_count  (out_removed_count)
  );

  // ---------------------------------------------------------------------
  // Region table predictor
  // ---------------------------------------------------------------------
  function automatic int first_cover(input int m, input addr_t a);
    for (int i = 0; i < slots_used[m]; i++) begin
      if (a >= slot_start[m][i] && a < slot_end[m][i]) return i;
    end
    return -1;
  endfunction

  function automatic region_resp_t apply_region_op(input int m, input region_req_t rq);
    region_resp_t rs;
    logic [AW:0]  sum;
    addr_t        stop;
    int           k;
    int           keep;
    int           removed;
    rs = '0;
    rs.status = ST_MISS;
    case (rq.op)
      OP_FIND: begin
        k = first_cover(m, rq.address);
        if (k >= 0) begin
          rs.status = ST_OK;
          rs.seg    = slot_seg[m][k];
          rs.start  = slot_start[m][k];
          rs.stop   = slot_end[m][k];
        end
      end
      OP_ADD: begin
        sum  = {1'b0, rq.address} + {1'b0, rq.length};
        stop = sum[AW] ? ADDR_MAX : sum[AW-1:0];
        if (rq.address == '0) begin
          rs.status = ST_ZERO;
        end else if (first_cover(m, rq.address) >= 0 || first_cover(m, stop) >= 0) begin
          rs.status = ST_OVERLAP;
        end else if (slots_used[m] >= N_SLOTS) begin
          rs.status = ST_FULL;
        end else begin
          slot_start[m][slots_used[m]] = rq.address;
          slot_end[m][slots_used[m]]   = stop;
          slot_seg[m][slots_used[m]]   = rq.seg;
          slots_used[m]++;
          rs.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        keep    = 0;
        removed = 0;
        for (int i = 0; i < slots_used[m]; i++) begin
          if (rq.address >= slot_start[m][i] && rq.address < slot_end[m][i]) begin
            removed++;
          end else begin
            slot_start[m][keep] = slot_start[m][i];
            slot_end[m][keep]   = slot_end[m][i];
            slot_seg[m][keep]   = slot_seg[m][i];
            keep++;
          end
        end
        slots_used[m] = keep;
        rs.status  = ST_OK;
        rs.removed = removed[REMOVED_W-1:0];
      end
      default: ;
    endcase
    return rs;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic addr_t rand48();
    return addr_t'({$urandom, $urandom});
  endfunction

  function automatic logic [SEG_W-1:0] rand_seg();
    return $urandom;
  endfunction

  // start inside one of 255 spaced regions of the low address space
  function automatic addr_t fresh_start();
    addr_t a;
    a = addr_t'($urandom_range(1, 255)) << 28;
    return a + addr_t'($urandom_range(0, 32'h03FF_FFFF));
  endfunction

  function automatic int pick_entry();
    if (slots_used[PLAN] == 0) return -1;
    return $urandom_range(0, slots_used[PLAN] - 1);
  endfunction

  function automatic addr_t point_in_entry();
    int    k;
    addr_t span;
    k = pick_entry();
    if (k < 0) return rand48();
    span = slot_end[PLAN][k] - slot_start[PLAN][k];
    if (span == '0) return slot_start[PLAN][k];
    return slot_start[PLAN][k] + rand48() % span;
  endfunction

  function automatic addr_t point_at_edge();
    int k;
    k = pick_entry();
    if (k < 0) return rand48();
    case ($urandom_range(0, 3))
      0:       return slot_start[PLAN][k];
      1:       return slot_end[PLAN][k] - 1'b1;
      2:       return slot_end[PLAN][k];
      default: return slot_start[PLAN][k] - 1'b1;
    endcase
  endfunction

  function automatic int idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input addr_t a, input addr_t len,
                               input logic [SEG_W-1:0] sid);
    region_req_t  rq;
    rq.op      = op;
    rq.address = a;
    rq.length  = len;
    rq.seg     = sid;
    void'(apply_region_op(PLAN, rq));
    request_queue.push_back(rq);
  endtask

  task automatic random_mix(input int count);
    int    pick;
    int    r;
    addr_t a;
    addr_t len;
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        r = $urandom_range(0, 99);
        if (r < 72)      a = fresh_start();
        else if (r < 84) a = point_in_entry();
        else if (r < 88) a = '0;
        else if (r < 94) a = rand48();
        else             a = ADDR_MAX - addr_t'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 82)      len = addr_t'($urandom_range(1, 32'h00FF_FFFF));
        else if (r < 90) len = '0;
        else if (r < 97) len = rand48();
        else             len = ADDR_MAX;
        queue_request(OP_ADD, a, len, rand_seg());
      end else if (pick < 78) begin
        r = $urandom_range(0, 99);
        if (r < 55)      a = point_in_entry();
        else if (r < 80) a = point_at_edge();
        else             a = rand48();
        queue_request(OP_FIND, a, rand48(), rand_seg());
      end else if (pick < 94) begin
        a = ($urandom_range(0, 99) < 75) ? point_in_entry() : rand48();
        queue_request(OP_REMOVE, a, rand48(), rand_seg());
      end else begin
        queue_request(OP_UNUSED, rand48(), rand48(), rand_seg());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Clock, stimulus and end of test
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : stimulus
    int    k;
    int    tries;
    addr_t a;
    addr_t len;

    queue_request(OP_FIND,   '0,                48'h10,     '0);
    queue_request(OP_FIND,   ADDR_MAX,          ADDR_MAX,   '1);
    queue_request(OP_REMOVE, 48'h1234,          '0,         '0);
    queue_request(OP_ADD,    '0,                48'h10,     32'h1111_2222);
    queue_request(OP_ADD,    48'h1000,          48'h100,    '1);
    queue_request(OP_ADD,    48'h800,           48'h1000,   '0);
    queue_request(OP_FIND,   48'h1000,          '0,         '0);
    queue_request(OP_FIND,   48'h10FF,          '0,         '0);
    queue_request(OP_FIND,   48'h1100,          '0,         '0);
    queue_request(OP_FIND,   48'h1800,          '0,         '0);
    queue_request(OP_FIND,   48'h7FF,           '0,         '0);
    queue_request(OP_ADD,    48'h1080,          48'h4,      32'hDEAD_BEEF);
    queue_request(OP_ADD,    48'h400,           48'h800,    32'hDEAD_BEEF);
    queue_request(OP_ADD,    48'hFFFF_0000_0000, ADDR_MAX,  32'h5A5A_A5A5);
    queue_request(OP_FIND,   ADDR_MAX - 1'b1,   '0,         '0);
    queue_request(OP_FIND,   ADDR_MAX,          '0,         '0);
    queue_request(OP_UNUSED, 48'h1000,          ADDR_MAX,   '1);
    queue_request(OP_REMOVE, 48'h1050,          '0,         '0);
    queue_request(OP_FIND,   48'h1050,          '0,         '0);
    queue_request(OP_FIND,   48'hFFFF_8000_0000, '0,        '0);
    queue_request(OP_ADD,    48'h1,             ADDR_MAX,   '1);
    queue_request(OP_FIND,   48'h1050,          '0,         '0);

    // empty the table, then stack nested ranges around one address
    tries = 0;
    while (slots_used[PLAN] > 0 && tries < 64) begin
      queue_request(OP_REMOVE, slot_start[PLAN][0], rand48(), rand_seg());
      tries++;
    end
    for (k = 0; k < N_SLOTS; k++) begin
      queue_request(OP_ADD, NEST_BASE - addr_t'(16 * k), addr_t'(32 * k + 16), rand_seg());
    end
    queue_request(OP_ADD, fresh_start(), 48'h40, rand_seg());
    queue_request(OP_FIND, NEST_BASE, '0, '0);
    queue_request(OP_REMOVE, NEST_BASE, '0, '0);

    // zero length ranges hold a slot but match nothing
    queue_request(OP_ADD, ADDR_MAX, 48'h20, rand_seg());
    queue_request(OP_FIND, ADDR_MAX, '0, '0);
    a = fresh_start();
    queue_request(OP_ADD, a, '0, rand_seg());
    queue_request(OP_FIND, a, '0, '0);

    random_mix(200);

    // drop huge ranges so the table can be filled to the last slot
    k = 0;
    while (k < slots_used[PLAN]) begin
      if (slot_end[PLAN][k] - slot_start[PLAN][k] > 48'h1_0000_0000)
        queue_request(OP_REMOVE, slot_start[PLAN][k], rand48(), rand_seg());
      else
        k++;
    end
    tries = 0;
    while (slots_used[PLAN] < N_SLOTS && tries < 600) begin
      a   = fresh_start();
      len = addr_t'($urandom_range(1, 32'h000F_FFFF));
      if (first_cover(PLAN, a) < 0 && first_cover(PLAN, a + len) < 0)
        queue_request(OP_ADD, a, len, rand_seg());
      tries++;
    end
    queue_request(OP_ADD, fresh_start(), 48'h10, rand_seg());
    queue_request(OP_ADD, point_in_entry(), 48'h10, rand_seg());
    queue_request(OP_ADD, '0, 48'h10, rand_seg());
    for (k = 0; k < 6; k++) queue_request(OP_FIND, point_in_entry(), rand48(), rand_seg());
    for (k = 0; k < 3; k++) queue_request(OP_REMOVE, point_in_entry(), rand48(), rand_seg());

    random_mix(60);

    total_reqs = request_queue.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (reqs_accepted != total_reqs) @(posedge clk);
    while (region_results_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (request_queue.size() > 0) begin
        next_req = request_queue.pop_front();
        in_valid      <= 1'b1;
        in_operation  <= next_req.op;
        in_address    <= next_req.address;
        in_length     <= next_req.length;
        in_segment_id <= next_req.seg;
        if (request_queue.size() >= 40 && $urandom_range(0, 99) < send_idle_pct)
          send_gap <= $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver back-pressure
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1'b1;
    if (cycle_cnt == '0) begin
      send_idle_pct <= idle_pct();
      recv_idle_pct <= idle_pct();
    end
  end

  // one long hold-off so the block backs up into the sender
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && reqs_accepted >= 60) begin
      hold_left <= 700;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign long_hold = (hold_left != 0);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      recv_burst <= 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (recv_burst > 0) begin
      out_stall  <= 1'b1;
      recv_burst <= recv_burst - 1;
    end else if (request_queue.size() >= 40 && $urandom_range(0, 99) < recv_idle_pct) begin
      out_stall  <= 1'b1;
      recv_burst <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and scoreboard
  // ---------------------------------------------------------------------
  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (region_results_due.size() == 0) begin
          $display("%0t: result with no transaction outstanding, status %0d",
                   $time, out_status);
          mismatches++;
        end else begin
          want_resp = region_results_due.pop_front();
          check_field("status",         64'(want_resp.status),  64'(out_status));
          check_field("hit_segment_id", 64'(want_resp.seg),     64'(out_hit_segment_id));
          check_field("hit_start",      64'(want_resp.start),   64'(out_hit_start));
          check_field("hit_end",        64'(want_resp.stop),    64'(out_hit_end));
          check_field("removed_count",  64'(want_resp.removed), 64'(out_removed_count));
        end
      end
      if (in_valid && !in_stall) begin
        seen_req.op      = in_operation;
        seen_req.address = in_address;
        seen_req.length  = in_length;
        seen_req.seg     = in_segment_id;
        region_results_due.push_back(apply_region_op(CHECK, seen_req));
        reqs_accepted++;
      end
    end
  end

endmodule
